FILE: src/i2dec_pkg.sv
`timescale 1ns / 1ps

package i2dec_pkg;

    // Fixed field sizes of the block.
    localparam int VALUE_W    = 64;
    localparam int FWIDTH_W   = 5;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 19;
    localparam int DIGIT_W    = 4;
    localparam int MAX_WIDTH  = 20;
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new input beat
        logic shift;  // one shift-add conversion step
        logic count;  // register digit count and fit flag
        logic emit;   // load the next character into the output register
    } i2dec_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a character this cycle
        logic last_pos;  // the next character is the rightmost one
    } i2dec_sts_t;

endpackage

FILE: src/i2dec_ctrl.sv
`timescale 1ns / 1ps

module i2dec_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  i2dec_pkg::i2dec_sts_t sts,
    output i2dec_pkg::i2dec_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_EMIT
    } state_t;

    state_t                              state_reg, state_next;
    logic [i2dec_pkg::STEP_CNT_W-1:0]    step_reg, step_next;

    // Command decode from the current state.
    always_comb begin
        cmd       = '0;
        s_tready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV: begin
                cmd.shift = 1'b1;
            end
            ST_COUNT: begin
                cmd.count = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_tvalid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == i2dec_pkg::STEP_CNT_W'(i2dec_pkg::CONV_STEPS - 1)) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free && sts.last_pos) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: src/i2dec_dp.sv
`timescale 1ns / 1ps

module i2dec_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [i2dec_pkg::VALUE_W-1:0]         in_value,
    input  logic [i2dec_pkg::FWIDTH_W-1:0]        in_field_width,
    input  logic                                  in_zero_fill,
    input  i2dec_pkg::i2dec_cmd_t                 cmd,
    output i2dec_pkg::i2dec_sts_t                 sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [i2dec_pkg::CHAR_W-1:0]          m_char_code,
    output logic                                  m_last_char,
    output logic                                  m_fits
);

    localparam logic [i2dec_pkg::CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [i2dec_pkg::CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [i2dec_pkg::CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam int FW = i2dec_pkg::FWIDTH_W;
    localparam int DW = i2dec_pkg::DIGIT_W;
    localparam int ND = i2dec_pkg::NUM_DIGITS;

    logic [i2dec_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [DW-1:0]                 bcd_reg [ND];
    logic [DW-1:0]                 bcd_next [ND];
    logic [DW-1:0]                 bcd_adj [ND];
    logic [FW-1:0]                 width_reg, width_next;
    logic                          zfill_reg;
    logic                          neg_reg;
    logic [FW-1:0]                 ndig_reg, ndig_next;
    logic                          ok_reg, ok_next;
    logic [FW-1:0]                 pos_reg;
    logic                          out_valid_reg;
    logic [i2dec_pkg::CHAR_W-1:0]  out_char_reg;
    logic                          out_last_reg;
    logic                          out_fits_reg;
    logic [FW-1:0]                 k_pos;
    logic [i2dec_pkg::CHAR_W-1:0]  char_next;

    // Input capture: magnitude and clamped field width.
    always_comb begin
        if (in_value[i2dec_pkg::VALUE_W-1]) begin
            mag_next = ~in_value + 1'b1;
        end else begin
            mag_next = in_value;
        end
        if (in_field_width == '0) begin
            width_next = FW'(1);
        end else if (in_field_width > FW'(i2dec_pkg::MAX_WIDTH)) begin
            width_next = FW'(i2dec_pkg::MAX_WIDTH);
        end else begin
            width_next = in_field_width;
        end
    end

    // Shift-add step: add three to each digit of five or more, then shift in one bit.
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            bcd_adj[i] = (bcd_reg[i] >= DW'(5)) ? bcd_reg[i] + DW'(3) : bcd_reg[i];
        end
        bcd_next[0] = {bcd_adj[0][DW-2:0], mag_reg[i2dec_pkg::VALUE_W-1]};
        for (int i = 1; i < ND; i++) begin
            bcd_next[i] = {bcd_adj[i][DW-2:0], bcd_adj[i-1][DW-1]};
        end
    end

    // Digit count from the highest nonzero digit; zero counts as one digit.
    always_comb begin
        ndig_next = FW'(1);
        for (int i = 1; i < ND; i++) begin
            if (bcd_reg[i] != '0) begin
                ndig_next = FW'(i + 1);
            end
        end
        ok_next = ((ndig_next + FW'(neg_reg)) <= width_reg);
    end

    // Character at the current position, counted from the right end.
    always_comb begin
        k_pos = width_reg - FW'(1) - pos_reg;
        if (k_pos < ndig_reg && k_pos < FW'(ND)) begin
            char_next = CHAR_ZERO + i2dec_pkg::CHAR_W'(bcd_reg[k_pos]);
        end else if (neg_reg && zfill_reg && pos_reg == '0) begin
            char_next = CHAR_MINUS;
        end else if (neg_reg && !zfill_reg && k_pos == ndig_reg) begin
            char_next = CHAR_MINUS;
        end else if (zfill_reg) begin
            char_next = CHAR_ZERO;
        end else begin
            char_next = CHAR_SPACE;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.last_pos = (pos_reg == width_reg - FW'(1));

    // Working registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg   <= mag_next;
            width_reg <= width_next;
            zfill_reg <= in_zero_fill;
            neg_reg   <= in_value[i2dec_pkg::VALUE_W-1];
            pos_reg   <= '0;
            for (int i = 0; i < ND; i++) begin
                bcd_reg[i] <= '0;
            end
        end
        if (cmd.shift) begin
            mag_reg <= {mag_reg[i2dec_pkg::VALUE_W-2:0], 1'b0};
            for (int i = 0; i < ND; i++) begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
        if (cmd.count) begin
            ndig_reg <= ndig_next;
            ok_reg   <= ok_next;
        end
        if (cmd.emit) begin
            pos_reg <= pos_reg + FW'(1);
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_char_reg <= char_next;
            out_last_reg <= sts.last_pos;
            out_fits_reg <= ok_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_char_code = out_char_reg;
    assign m_last_char = out_last_reg;
    assign m_fits      = out_fits_reg;

endmodule

FILE: src/int64_to_fixed_width_decimal_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: value[63:0], field_width[68:64], zero_fill[69]
// m_       out  m_tvalid/m_tready  m_tdata: char_code[7:0]; m_tlast: last_char; m_tuser: fits
//
// One input beat is captured, then run through 64 shift-add steps (one per magnitude bit)
// of the binary-to-decimal loop, then its digit count is registered, and then the field
// is sent one character per cycle while the output register can take a character.
// Reset is synchronous and active low; it returns the controller to idle and empties
// the output register. Low m_tready holds the field where it is; a new beat is taken
// as soon as the last character sits in the output register.

module int64_to_fixed_width_decimal_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value[63:0], field_width[68:64], zero_fill[69], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code[7:0]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // fits[0]
);

    i2dec_pkg::i2dec_cmd_t cmd;
    i2dec_pkg::i2dec_sts_t sts;

    // Sequencer.
    i2dec_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Conversion and character datapath.
    i2dec_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_value       (s_tdata[63:0]),
        .in_field_width (s_tdata[68:64]),
        .in_zero_fill   (s_tdata[69]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_char_code    (m_tdata),
        .m_last_char    (m_tlast),
        .m_fits         (m_tuser[0])
    );

endmodule
